// ===== sv/cgp_pkg.sv =====
// shared types and constants of the color gradient palette
package cgp_pkg;

  localparam int SLOT_W  = 4;
  localparam int POS_W   = 9;
  localparam int COLOR_W = 24;
  localparam int IDX_W   = 8;
  localparam int CH_W    = 8;
  localparam int NUM_CH  = 3;
  localparam int CFG_W   = 5;
  localparam int DIV_STEPS = CH_W;
  localparam int CNT_W   = $clog2(DIV_STEPS);

  localparam logic       FUNC_LOAD = 1'b0;
  localparam logic       FUNC_READ = 1'b1;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd2;
  localparam logic [CFG_W-1:0] MIN_POINTS = 5'd2;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_DROP,
    CMD_READ,
    CMD_MISS
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [SLOT_W-1:0]   slot;
    logic [POS_W-1:0]    pos;
    logic [COLOR_W-1:0]  color;
    logic [IDX_W-1:0]    idx;
  } cmd_t;

  typedef struct packed {
    logic ld;
    logic step;
  } lane_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HI,
    ST_SCAN,
    ST_DIV,
    ST_OUT
  } back_state_t;

endpackage

// ===== sv/cgp_front.sv =====
// front end: classifies incoming transactions and queues them for the back end
module cgp_front
  import cgp_pkg::*;
#(
  parameter int MAX_POINTS = 16,
  parameter int MAP_SIZE   = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               func,
  input  logic [SLOT_W-1:0]  point_slot,
  input  logic [POS_W-1:0]   point_position,
  input  logic [COLOR_W-1:0] point_color,
  input  logic [IDX_W-1:0]   map_index,
  output logic               cmd_valid,
  output cmd_t               cmd,
  input  logic               cmd_pop
);

  localparam int DEPTH = 2;

  cmd_t       q_r [DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cmd_in;
  logic       push;

  always_comb begin
    cmd_in.slot  = point_slot;
    cmd_in.pos   = point_position;
    cmd_in.color = point_color;
    cmd_in.idx   = map_index;
    if (func == FUNC_LOAD) begin
      cmd_in.kind = (int'(point_slot) < MAX_POINTS) ? CMD_LOAD : CMD_DROP;
    end else begin
      cmd_in.kind = (int'(map_index) < MAP_SIZE) ? CMD_READ : CMD_MISS;
    end
  end

  assign in_tready = (cnt_r != 2'(DEPTH));
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== sv/cgp_lane.sv =====
// one color channel: product, restoring division and floor correction
module cgp_lane
  import cgp_pkg::*;
(
  input  logic             clk,
  input  lane_ctrl_t       ctrl,
  input  logic [CH_W-1:0]  a,
  input  logic [CH_W-1:0]  b,
  input  logic [IDX_W-1:0] off,
  input  logic [POS_W-1:0] span,
  output logic [CH_W-1:0]  res
);

  logic [CH_W-1:0]    a_r;
  logic               neg_r;
  logic [POS_W-1:0]   rem_r;
  logic [CH_W-1:0]    low_r;
  logic               neg;
  logic [CH_W-1:0]    dmag;
  logic [2*CH_W-1:0]  prod;
  logic [POS_W:0]     trial;
  logic               ge;
  logic [CH_W-1:0]    qd;

  always_comb begin
    neg   = (b < a);
    dmag  = neg ? (a - b) : (b - a);
    prod  = (2*CH_W)'(dmag) * (2*CH_W)'(off);
    trial = {rem_r, low_r[CH_W-1]};
    ge    = (trial >= {1'b0, span});
    qd    = low_r + CH_W'(neg_r && (rem_r != '0));
    res   = neg_r ? (a_r - qd) : (a_r + qd);
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld) begin
      a_r   <= a;
      neg_r <= neg;
      rem_r <= {1'b0, prod[2*CH_W-1:CH_W]};
      low_r <= prod[CH_W-1:0];
    end else if (ctrl.step) begin
      rem_r <= ge ? POS_W'(trial - {1'b0, span}) : trial[POS_W-1:0];
      low_r <= {low_r[CH_W-2:0], ge};
    end
  end

endmodule

// ===== sv/cgp_back.sv =====
// back end: point store, segment scan, channel lanes and result register
module cgp_back
  import cgp_pkg::*;
#(
  parameter int MAX_POINTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CFG_W-1:0]   points_in_use,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [COLOR_W-1:0] out_color,
  output logic               out_found
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int SW = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int EW = POS_W + COLOR_W;

  logic [EW-1:0]         mem [MAX_POINTS];
  logic [MAX_POINTS-1:0] vld_r;
  logic [EW-1:0]         mem_q_r;
  logic                  vld_q_r;

  back_state_t         state_r, state_nxt;
  logic [AW-1:0]       seg_r, seg_nxt;
  logic [POS_W-1:0]    hi_pos_r, hi_pos_nxt;
  logic [COLOR_W-1:0]  hi_col_r, hi_col_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [POS_W-1:0]    span_r, span_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                found_r, found_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0]  out_color_r, out_color_nxt;
  logic                out_found_r, out_found_nxt;

  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [SW-1:0]       slot_w;
  logic [AW-1:0]       nm1;
  logic [CFG_W-1:0]    cfg_m1;
  logic                few_pts;
  logic [POS_W-1:0]    ent_pos;
  logic [COLOR_W-1:0]  ent_col;
  logic                match;
  logic [IDX_W-1:0]    off;
  logic                out_free;
  logic                out_ld;
  lane_ctrl_t          lane_ctrl;
  logic [COLOR_W-1:0]  lane_res;

  always_comb begin
    cfg_m1  = points_in_use - 5'd1;
    few_pts = (points_in_use < MIN_POINTS);
    if (int'(points_in_use) >= MAX_POINTS) begin
      nm1 = AW'(MAX_POINTS - 1);
    end else begin
      nm1 = AW'(cfg_m1);
    end
    slot_w   = SW'(cmd.slot);
    ent_pos  = vld_q_r ? mem_q_r[EW-1:COLOR_W] : '0;
    ent_col  = vld_q_r ? mem_q_r[COLOR_W-1:0] : '0;
    match    = (ent_pos <= {1'b0, idx_r}) && ({1'b0, idx_r} < hi_pos_r);
    off      = idx_r - ent_pos[IDX_W-1:0];
    out_free = !out_valid_r || out_tready;
  end

  always_comb begin
    state_nxt     = state_r;
    seg_nxt       = seg_r;
    hi_pos_nxt    = hi_pos_r;
    hi_col_nxt    = hi_col_r;
    idx_nxt       = idx_r;
    span_nxt      = span_r;
    cnt_nxt       = cnt_r;
    found_nxt     = found_r;
    out_color_nxt = out_color_r;
    out_found_nxt = out_found_r;
    rd_addr       = seg_r;
    wr_en         = 1'b0;
    cmd_pop       = 1'b0;
    out_ld        = 1'b0;
    lane_ctrl     = '0;
    case (state_r)
      ST_IDLE: begin
        rd_addr = nm1;
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_LOAD: begin
              wr_en   = 1'b1;
              cmd_pop = 1'b1;
            end
            CMD_DROP: begin
              cmd_pop = 1'b1;
            end
            CMD_READ: begin
              cmd_pop = 1'b1;
              idx_nxt = cmd.idx;
              if (few_pts) begin
                found_nxt = 1'b0;
                state_nxt = ST_OUT;
              end else begin
                seg_nxt   = nm1 - AW'(1);
                state_nxt = ST_HI;
              end
            end
            CMD_MISS: begin
              if (out_free) begin
                cmd_pop       = 1'b1;
                out_ld        = 1'b1;
                out_color_nxt = '0;
                out_found_nxt = 1'b0;
              end
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      ST_HI: begin
        hi_pos_nxt = ent_pos;
        hi_col_nxt = ent_col;
        rd_addr    = seg_r;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        if (match) begin
          lane_ctrl.ld = 1'b1;
          span_nxt     = hi_pos_r - ent_pos;
          cnt_nxt      = '0;
          state_nxt    = ST_DIV;
        end else begin
          hi_pos_nxt = ent_pos;
          hi_col_nxt = ent_col;
          if (seg_r == '0) begin
            found_nxt = 1'b0;
            state_nxt = ST_OUT;
          end else begin
            seg_nxt = seg_r - AW'(1);
            rd_addr = seg_r - AW'(1);
          end
        end
      end
      ST_DIV: begin
        lane_ctrl.step = 1'b1;
        cnt_nxt        = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          found_nxt = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_ld        = 1'b1;
          out_color_nxt = found_r ? lane_res : '0;
          out_found_nxt = found_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = out_ld ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    cgp_lane u_lane (
      .clk  (clk),
      .ctrl (lane_ctrl),
      .a    (ent_col[c*CH_W +: CH_W]),
      .b    (hi_col_r[c*CH_W +: CH_W]),
      .off  (off),
      .span (span_r),
      .res  (lane_res[c*CH_W +: CH_W])
    );
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot_w[AW-1:0]] <= {cmd.pos, cmd.color};
    end
    mem_q_r <= mem[rd_addr];
    vld_q_r <= vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[slot_w[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seg_r       <= seg_nxt;
    hi_pos_r    <= hi_pos_nxt;
    hi_col_r    <= hi_col_nxt;
    idx_r       <= idx_nxt;
    span_r      <= span_nxt;
    cnt_r       <= cnt_nxt;
    found_r     <= found_nxt;
    out_color_r <= out_color_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_color  = out_color_r;
  assign out_found  = out_found_r;

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r == CNT_W'(DIV_STEPS - 1)) |=> (state_r == ST_OUT && found_r))
    else $error("division did not hand over a found result");

  a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ($past(state_r) == ST_HI || $past(state_r) == ST_SCAN))
    else $error("scan entered without reading the upper point");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (cmd_valid && state_r == ST_IDLE))
    else $error("command popped outside idle");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_color_r) && $stable(out_found_r)))
    else $error("pending result overwritten");

endmodule

// ===== sv/color_gradient_palette.sv =====
// top level of the piecewise linear color gradient palette
// A load transaction writes one control point (position and packed 24-bit color, red in
// the low byte) and returns nothing; a read transaction returns the color interpolated on
// the highest segment whose start is at or below map_index and whose end is above it, with
// entry_found low and color zero when no segment covers it. Transactions queue in a
// two-entry buffer in front of the executing back end. A load is written to the point
// store from the idle state without leaving it. In a read, the segment scan walks the
// point store downward one entry per cycle through its single read port, then the three
// channels divide in parallel, one quotient bit per cycle, and the result is registered.
// Reads out of the map or with fewer than two points skip the scan and the division. The
// point store is cleared at reset through per-entry valid flags, so no clearing pass is
// needed and the block accepts transactions right after reset.
module color_gradient_palette
  import cgp_pkg::*;
#(
  parameter int MAX_POINTS = 16,
  parameter int MAP_SIZE   = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // point_slot, point_position, point_color, map_index, zero fill
  input  logic [47:0]      in_tdata,
  // func
  input  logic             in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // entry_color
  output logic [23:0]      out_tdata,
  // entry_found
  output logic             out_tuser,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [CFG_W-1:0] points_in_use_r, points_in_use_nxt;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_pop;

  assign points_in_use_nxt = cfg_we ? cfg_data : points_in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_in_use_r <= CFG_RESET;
    end else begin
      points_in_use_r <= points_in_use_nxt;
    end
  end

  cgp_front #(
    .MAX_POINTS (MAX_POINTS),
    .MAP_SIZE   (MAP_SIZE)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .func           (in_tuser),
    .point_slot     (in_tdata[3:0]),
    .point_position (in_tdata[12:4]),
    .point_color    (in_tdata[36:13]),
    .map_index      (in_tdata[44:37]),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  cgp_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .points_in_use (points_in_use_r),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_color     (out_tdata),
    .out_found     (out_tuser)
  );

endmodule
